### rtl/core/pcx_pkg.sv
// shared types and constants for the pcx run-length palette decoder
package pcx_pkg;

  // field widths
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned COUNT_W = 6;

  // input op codes
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_CODE    = 1'b1;

  // top two bits of a run header byte
  localparam logic [1:0] RUN_MARK = 2'b11;

  // command queue size
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_CW    = 2;

  // input transaction
  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] entry_color;
    logic [IDX_W-1:0]   code_byte;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               last_of_run;
  } out_t;

  // command kinds passed from front to back
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EMIT  = 1'b1
  } cmd_kind_t;

  // one queued command
  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
  } cmd_t;

endpackage

### rtl/core/pcx_front.sv
// front end: accepts input transactions, tracks run headers, issues commands
module pcx_front
  import pcx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  in_t  in_data,
  input  logic q_full,
  output logic in_stall,
  output logic q_push,
  output cmd_t q_cmd
);

  logic               awaiting_r;
  logic               awaiting_nxt;
  logic [COUNT_W-1:0] pend_r;
  logic [COUNT_W-1:0] pend_nxt;
  logic               accept;
  logic               is_write;
  logic               is_value;
  logic               is_header;
  logic               is_literal;

  // take an item whenever the queue has room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // classify the item
  assign is_write   = (in_data.op == OP_PALETTE);
  assign is_value   = (in_data.op == OP_CODE) && awaiting_r;
  assign is_header  = (in_data.op == OP_CODE) && !awaiting_r &&
                      (in_data.code_byte[IDX_W-1 -: 2] == RUN_MARK);
  assign is_literal = (in_data.op == OP_CODE) && !awaiting_r && !is_header;

  // build the command for the back end
  always_comb begin
    q_cmd       = '0;
    q_cmd.color = in_data.entry_color;
    if (is_write) begin
      q_cmd.kind  = CMD_WRITE;
      q_cmd.index = in_data.entry_index;
      q_cmd.count = '0;
    end else begin
      q_cmd.kind  = CMD_EMIT;
      q_cmd.index = in_data.code_byte;
      q_cmd.count = is_value ? pend_r : COUNT_W'(1);
    end
  end

  // zero-length runs push nothing
  assign q_push = accept &&
                  (is_write || is_literal || (is_value && (pend_r != '0)));

  // run header tracking
  always_comb begin
    awaiting_nxt = awaiting_r;
    pend_nxt     = pend_r;
    if (accept && is_value) begin
      awaiting_nxt = 1'b0;
      pend_nxt     = '0;
    end else if (accept && is_header) begin
      awaiting_nxt = 1'b1;
      pend_nxt     = in_data.code_byte[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      pend_r     <= '0;
    end else begin
      awaiting_r <= awaiting_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

### rtl/core/pcx_cmd_fifo.sv
// small command queue between front and back end
module pcx_cmd_fifo
  import pcx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  cmd_t                slots_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] fill_r;
  logic                do_push;
  logic                do_pop;

  assign full     = (fill_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slots_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - QUEUE_CW'(1);
      end
    end
  end

endmodule

### rtl/core/pcx_back.sv
// back end: palette memory, run expansion and output register
module pcx_back
  import pcx_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  cmd_t q_cmd,
  output logic q_pop,
  input  logic out_stall,
  output logic out_valid,
  output out_t out_data
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];
  state_t             state_r;
  state_t             state_nxt;
  logic [COUNT_W-1:0] remain_r;
  logic [COUNT_W-1:0] remain_nxt;
  logic [COLOR_W-1:0] rd_data_r;
  logic               rd_oor_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_t               out_data_r;
  logic               idx_in_range;
  logic               mem_we;
  logic               mem_re;
  logic               load_out;

  assign idx_in_range = ({1'b0, q_cmd.index} < (IDX_W + 1)'(PALETTE_DEPTH));
  assign q_pop        = (state_r == ST_IDLE) && !q_empty;
  assign mem_we       = q_pop && (q_cmd.kind == CMD_WRITE) && idx_in_range;
  assign mem_re       = q_pop && (q_cmd.kind == CMD_EMIT);
  assign load_out     = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // palette memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      palette_mem[q_cmd.index[AW-1:0]] <= q_cmd.color;
    end
    if (mem_re) begin
      rd_data_r <= palette_mem[q_cmd.index[AW-1:0]];
      rd_oor_r  <= !idx_in_range;
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    remain_nxt = remain_r;
    unique case (state_r)
      ST_IDLE: begin
        if (mem_re) begin
          state_nxt  = ST_EMIT;
          remain_nxt = q_cmd.count;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          remain_nxt = remain_r - COUNT_W'(1);
          if (remain_r == COUNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.pixel_color <= rd_oor_r ? '0 : rd_data_r;
      out_data_r.last_of_run <= (remain_r == COUNT_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/pcx_rle_palette_decoder_top.sv
// top level of the pcx run-length palette decoder
//
// Input channel (in_valid / in_stall / in_data): each transaction either
// writes one palette entry (op 0) or carries one encoded stream byte (op 1).
// A byte with both top bits set is a run header; the next code byte is the
// palette index repeated count times. Other bytes are single literal pixels.
// Output channel (out_valid / out_stall / out_data): one palette color per
// transaction, last_of_run marks the final pixel caused by one input byte.
// A literal passes the command queue, the registered palette read and the
// output register before it shows on out_valid. The back end takes a new
// command only when idle, so it expands a whole run before the next one;
// its single palette memory port and its output register, one pixel per
// cycle unless out_stall holds it, bound its pace. A two-entry command
// queue lets the front keep taking items while the back end expands a run;
// headers push no command. in_stall rises only when that queue is full.
// Reset clears the run tracking, the queue and the output register; palette
// contents are undefined until written. A stalled output holds its pixel
// and the back end waits, filling the queue and then stalling the input.
module pcx_rle_palette_decoder_top
  import pcx_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // item intake and classification
  pcx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // command queue
  pcx_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // palette lookup and run expansion
  pcx_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### rtl/core/pcx_port_checker.sv
// port-level checks for the pcx decoder top level, with bind
module pcx_port_checker
  import pcx_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  // no output right after reset
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // queue is empty after reset so input is not stalled
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // a run continues with the same color in the next cycle
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_run |=>
      out_valid && $stable(out_data.pixel_color))
    else $error("run broken before its last pixel");

endmodule

bind pcx_rle_palette_decoder_top pcx_port_checker u_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### test/testbench.sv
// self-checking testbench for the pcx run-length palette decoder
`timescale 1ns / 1ps

module testbench;
  import pcx_pkg::*;

  localparam int unsigned PAL_DEPTH   = 256;
  localparam int unsigned TOTAL_ITEMS = 460;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned MAX_SHOWN   = 10;

  // one row of the directed table
  typedef struct packed {
    in_t                item;
    bit                 typed;
    logic [COLOR_W-1:0] color;
    int                 pixels;
  } step_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  // decoder state mirrored from accepted transactions
  logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
  bit                 run_armed;
  logic [COUNT_W-1:0] run_len;

  // pixels still to arrive, oldest first
  out_t exp_pixels[$];

  // palette entries known to be written, for picking safe indices
  bit         written [PAL_DEPTH];
  logic [7:0] any_idx[$];
  logic [7:0] lit_idx[$];

  step_t directed_rows[$];

  int items_sent;
  int mismatches;
  int hold_left;
  bit quiet;

  pcx_rle_palette_decoder_top #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

  // expands one accepted transaction into its pixel color and count
  function automatic void decode_byte(input in_t t, output logic [COLOR_W-1:0] color,
                                      output int pixels);
    color  = '0;
    pixels = 0;
    if (t.op == OP_PALETTE) begin
      if (t.entry_index < PAL_DEPTH) pal_mem[t.entry_index] = t.entry_color;
    end else if (run_armed) begin
      // value byte of a run is always an index, whatever its top bits
      run_armed = 1'b0;
      pixels    = int'(run_len);
      run_len   = '0;
      color     = (t.code_byte < PAL_DEPTH) ? pal_mem[t.code_byte] : '0;
    end else if (t.code_byte[7:6] == RUN_MARK) begin
      run_len   = t.code_byte[COUNT_W-1:0];
      run_armed = 1'b1;
    end else begin
      color  = (t.code_byte < PAL_DEPTH) ? pal_mem[t.code_byte] : '0;
      pixels = 1;
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // transaction with every field random
  function automatic in_t rand_item(input logic op);
    in_t t;
    t.op          = op;
    t.entry_index = IDX_W'($urandom_range(0, 255));
    t.entry_color = COLOR_W'($urandom_range(0, 24'hFFFFFF));
    t.code_byte   = IDX_W'($urandom_range(0, 255));
    return t;
  endfunction

  function automatic void note_write(input logic [7:0] idx);
    if (!written[idx]) begin
      written[idx] = 1'b1;
      any_idx = {any_idx, idx};
      if (idx[7:6] != RUN_MARK) lit_idx = {lit_idx, idx};
    end
  endfunction

  // directed palette write, no pixels
  function automatic void add_write(input logic [7:0] idx, input logic [COLOR_W-1:0] color);
    step_t s;
    s.item             = rand_item(OP_PALETTE);
    s.item.entry_index = idx;
    s.item.entry_color = color;
    s.typed            = 1'b1;
    s.color            = '0;
    s.pixels           = 0;
    note_write(idx);
    directed_rows = {directed_rows, s};
  endfunction

  // directed code byte, with its result typed in or left to the predictor
  function automatic void add_code(input logic [7:0] code, input bit typed,
                                   input logic [COLOR_W-1:0] color, input int pixels);
    step_t s;
    s.item           = rand_item(OP_CODE);
    s.item.code_byte = code;
    s.typed          = typed;
    s.color          = color;
    s.pixels         = pixels;
    directed_rows = {directed_rows, s};
  endfunction

  // offers one transaction, waits for acceptance, then queues its pixels
  task automatic send_item(input in_t t, input bit typed, input logic [COLOR_W-1:0] tcolor,
                           input int tpixels);
    int                 gap;
    logic [COLOR_W-1:0] color;
    int                 pixels;
    out_t               px;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(t, color, pixels);
    if (typed) begin
      color  = tcolor;
      pixels = tpixels;
    end
    for (int k = 1; k <= pixels; k++) begin
      px.pixel_color = color;
      px.last_of_run = (k == pixels);
      exp_pixels = {exp_pixels, px};
    end
    items_sent++;
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 30) stall_left = idle_len();
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // compare each accepted pixel with the oldest expectation
  always @(posedge clk) begin : check_pixels
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected pixel: color %06h last %0b",
                   out_data.pixel_color, out_data.last_of_run);
      end else begin
        want = exp_pixels.pop_front();
        if (out_data.pixel_color !== want.pixel_color ||
            out_data.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("pixel mismatch: expected color %06h last %0b, got color %06h last %0b",
                     want.pixel_color, want.last_of_run,
                     out_data.pixel_color, out_data.last_of_run);
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    in_t              t;
    int               kind;
    logic [COUNT_W-1:0] count;
    bit               pressed;
    int               r;
    items_sent = 0;
    mismatches = 0;
    hold_left  = 0;
    quiet      = 1'b0;
    pressed    = 1'b0;
    run_armed  = 1'b0;
    run_len    = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: palette extremes, literals, runs and their corner cases
    add_write(8'h00, 24'h000000);
    add_write(8'hFF, 24'hFFFFFF);
    add_write(8'h3F, 24'h123456);
    add_write(8'hC5, 24'hA5C3E1);
    add_write(8'hBF, 24'h5A3C1E);
    add_code(8'h00, 1'b1, 24'h000000, 1);
    add_code(8'h3F, 1'b1, 24'h123456, 1);
    add_code(8'hBF, 1'b1, 24'h5A3C1E, 1);
    add_code({RUN_MARK, 6'd3}, 1'b1, '0, 0);
    add_code(8'h00, 1'b1, 24'h000000, 3);
    add_code({RUN_MARK, 6'd63}, 1'b1, '0, 0);
    add_code(8'hFF, 1'b1, 24'hFFFFFF, 63);
    // zero-length run swallows its value byte
    add_code({RUN_MARK, 6'd0}, 1'b1, '0, 0);
    add_code(8'h3F, 1'b1, '0, 0);
    // value byte that looks like a run header
    add_code({RUN_MARK, 6'd1}, 1'b1, '0, 0);
    add_code(8'hC5, 1'b1, 24'hA5C3E1, 1);
    // palette writes while a run is pending
    add_code({RUN_MARK, 6'd2}, 1'b1, '0, 0);
    add_write(8'h80, 24'h0F0F0F);
    add_code(8'h80, 1'b1, 24'h0F0F0F, 2);
    add_code({RUN_MARK, 6'd4}, 1'b0, '0, 0);
    add_write(8'hC5, 24'h777777);
    add_code(8'hC5, 1'b0, '0, 0);
    add_code(8'h80, 1'b0, '0, 0);
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed,
                directed_rows[i].color, directed_rows[i].pixels);

    // random: palette writes, literals and runs with random content
    while (items_sent < TOTAL_ITEMS) begin
      quiet = ((items_sent / 60) % 4) == 2;
      if (!pressed && items_sent >= 250) begin
        pressed   = 1'b1;
        hold_left = HOLD_LEN;
      end
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        t = rand_item(OP_PALETTE);
        r = $urandom_range(0, 9);
        if (r == 0) t.entry_color = '0;
        else if (r == 1) t.entry_color = '1;
        note_write(t.entry_index);
        send_item(t, 1'b0, '0, 0);
      end else if (kind < 55) begin
        t = rand_item(OP_CODE);
        t.code_byte = lit_idx[$urandom_range(0, lit_idx.size() - 1)];
        send_item(t, 1'b0, '0, 0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) count = '0;
        else if (r < 75) count = COUNT_W'($urandom_range(1, 6));
        else if (r < 92) count = COUNT_W'($urandom_range(7, 20));
        else count = COUNT_W'($urandom_range(21, 63));
        t = rand_item(OP_CODE);
        t.code_byte = {RUN_MARK, count};
        send_item(t, 1'b0, '0, 0);
        // sometimes a palette write slips in before the value byte
        if ($urandom_range(0, 99) < 15) begin
          t = rand_item(OP_PALETTE);
          note_write(t.entry_index);
          send_item(t, 1'b0, '0, 0);
        end
        t = rand_item(OP_CODE);
        t.code_byte = any_idx[$urandom_range(0, any_idx.size() - 1)];
        send_item(t, 1'b0, '0, 0);
      end
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    // drain
    while (exp_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
